[design/ctp_pkg.sv]
package ctp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_INT    = 3'd1,
    ST_MISSING_OP = 3'd2,
    ST_INVALID_OP = 3'd3,
    ST_LEN_RANGE  = 3'd4
  } status_t;

  // Result item kinds
  typedef enum logic {
    KIND_OP  = 1'b0,
    KIND_END = 1'b1
  } kind_t;

  localparam int unsigned ACC_W      = 32;
  localparam int unsigned LEN_W      = 28;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned PROD_W     = ACC_W + 4;
  localparam logic [ACC_W-1:0] MAX_OP_LENGTH = 32'h0FFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MAX       = 32'hFFFF_FFFF;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // BAM operation codes
  localparam logic [CODE_W-1:0] OP_M  = 4'd0;
  localparam logic [CODE_W-1:0] OP_I  = 4'd1;
  localparam logic [CODE_W-1:0] OP_D  = 4'd2;
  localparam logic [CODE_W-1:0] OP_N  = 4'd3;
  localparam logic [CODE_W-1:0] OP_S  = 4'd4;
  localparam logic [CODE_W-1:0] OP_H  = 4'd5;
  localparam logic [CODE_W-1:0] OP_P  = 4'd6;
  localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
  localparam logic [CODE_W-1:0] OP_X  = 4'd8;

  // FIFO sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic [2:0]        status;
    logic              run_end;
  } result_t;

  // Push request from the parser to the result queue
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } op_lookup_t;

  function automatic op_lookup_t op_lookup(input logic [7:0] c);
    op_lookup_t r;
    r.valid = 1'b1;
    r.code  = OP_M;
    case (c)
      8'h4D: r.code = OP_M;
      8'h49: r.code = OP_I;
      8'h44: r.code = OP_D;
      8'h4E: r.code = OP_N;
      8'h53: r.code = OP_S;
      8'h48: r.code = OP_H;
      8'h50: r.code = OP_P;
      8'h3D: r.code = OP_EQ;
      8'h58: r.code = OP_X;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[design/ctp_parse.sv]
module ctp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_ready,
  input  logic [7:0]       text_byte,
  input  logic             record_last,
  input  logic             room,
  output ctp_pkg::push_t   push,
  output ctp_pkg::result_t first_entry,
  output ctp_pkg::result_t second_entry
);
  import ctp_pkg::*;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             advance;

  logic [ACC_W-1:0] acc, acc_next;
  logic             ovf, ovf_next;
  logic             seen, seen_next;
  logic             start, start_next;
  status_t          err, err_next;

  logic             lone_star;
  logic             is_digit;
  logic [PROD_W-1:0] prod;
  op_lookup_t       lk;
  logic             op_emit;
  status_t          end_status;

  // Input register: take a new transaction when empty or draining
  assign advance    = s1_valid && room;
  assign text_ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_ready) begin
      s1_valid <= text_valid;
    end
    if (text_ready && text_valid) begin
      s1_byte <= text_byte;
      s1_last <= record_last;
    end
  end

  // Decode the held byte
  assign lone_star = start && (s1_byte == CHAR_STAR) && s1_last;
  assign is_digit  = (s1_byte >= CHAR_ZERO) && (s1_byte <= CHAR_NINE);
  assign prod      = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                   + {{(PROD_W-4){1'b0}}, s1_byte[3:0]};
  assign lk        = op_lookup(s1_byte);

  // Next parse state and results
  always_comb begin
    acc_next   = acc;
    ovf_next   = ovf;
    seen_next  = seen;
    err_next   = err;
    op_emit    = 1'b0;
    end_status = ST_OK;

    if (err == ST_OK && !lone_star) begin
      if (is_digit) begin
        if (!ovf) begin
          if (prod > {4'b0000, ACC_MAX}) begin
            ovf_next = 1'b1;
          end else begin
            acc_next = prod[ACC_W-1:0];
          end
        end
        seen_next = 1'b1;
      end else begin
        if (!seen || ovf) begin
          err_next = ST_BAD_INT;
        end else if (!lk.valid) begin
          err_next = ST_INVALID_OP;
        end else if (acc > MAX_OP_LENGTH) begin
          err_next = ST_LEN_RANGE;
        end else begin
          op_emit = 1'b1;
        end
        acc_next  = '0;
        ovf_next  = 1'b0;
        seen_next = 1'b0;
      end
    end
    start_next = 1'b0;

    // Close the record and return to reset values
    if (s1_last) begin
      end_status = err_next;
      if (err_next == ST_OK && seen_next) begin
        end_status = ovf_next ? ST_BAD_INT : ST_MISSING_OP;
      end
      acc_next   = '0;
      ovf_next   = 1'b0;
      seen_next  = 1'b0;
      start_next = 1'b1;
      err_next   = ST_OK;
    end
  end

  // Hold parse state until the transaction advances
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      ovf   <= 1'b0;
      seen  <= 1'b0;
      start <= 1'b1;
      err   <= ST_OK;
    end else if (advance) begin
      acc   <= acc_next;
      ovf   <= ovf_next;
      seen  <= seen_next;
      start <= start_next;
      err   <= err_next;
    end
  end

  // Form up to two result entries
  always_comb begin
    result_t op_r, end_r;
    op_r.kind    = KIND_OP;
    op_r.code    = lk.code;
    op_r.length  = acc[LEN_W-1:0];
    op_r.status  = ST_OK;
    op_r.run_end = !s1_last;
    end_r.kind    = KIND_END;
    end_r.code    = '0;
    end_r.length  = '0;
    end_r.status  = end_status;
    end_r.run_end = 1'b1;

    push.first   = advance && (op_emit || s1_last);
    push.second  = advance && op_emit && s1_last;
    first_entry  = op_emit ? op_r : end_r;
    second_entry = end_r;
  end

endmodule

[design/ctp_fifo.sv]
module ctp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  ctp_pkg::push_t   push,
  input  ctp_pkg::result_t first_entry,
  input  ctp_pkg::result_t second_entry,
  output logic             room,
  output logic             result_valid,
  input  logic             result_ready,
  output ctp_pkg::result_t head
);
  import ctp_pkg::*;

  result_t          entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  assign result_valid = (count != '0);
  assign pop          = result_valid && result_ready;
  assign room         = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign head         = entries[rd_ptr];
  assign n_push       = CNT_W'(push.first) + CNT_W'(push.second);
  assign count_next   = count + n_push - CNT_W'(pop);

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= first_entry;
    end
    if (push.second) begin
      entries[wr_ptr + PTR_W'(1)] <= second_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

[design/cigar_text_parser_core.sv]
// CIGAR text parser: feed one record byte per text transaction, with
// record_last set on its final byte. Each operation character emits an
// operation result (BAM code and length), and the last byte of a record also
// emits a record-end result carrying the status; a lone '*' record gives only
// the record end. If the status is not ok, drop the operations already
// received for that record. Bytes are taken at one per clock while the queue
// has room. A byte that ends a record right after an operation yields two
// results, but that operation needs a digit byte before it, which yields
// none, so a consumer that takes one result per clock never stalls the
// input; the input holds only while more than two results wait in the queue.
// A taken byte waits in an input register until the result queue has room;
// the four-entry result queue decouples the two sides.
module cigar_text_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        record_last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [3:0]  op_code,
  output logic [27:0] op_length,
  output logic [2:0]  status,
  output logic        run_end
);
  import ctp_pkg::*;

  push_t   push;
  result_t first_entry, second_entry, head;
  logic    room;

  ctp_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .record_last  (record_last),
    .room         (room),
    .push         (push),
    .first_entry  (first_entry),
    .second_entry (second_entry)
  );

  ctp_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .first_entry  (first_entry),
    .second_entry (second_entry),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  // Drive result fields from the queue head
  assign result_kind = head.kind;
  assign op_code     = head.code;
  assign op_length   = head.length;
  assign status      = head.status;
  assign run_end     = head.run_end;

endmodule

[design/ctp_checker.sv]
module ctp_checker (
  input logic        clk,
  input logic        rst,
  input logic        text_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic        result_kind,
  input logic [3:0]  op_code,
  input logic [27:0] op_length,
  input logic [2:0]  status,
  input logic        run_end
);
  import ctp_pkg::*;

  // Hold a stalled result transaction
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_kind)
      && $stable(op_code) && $stable(op_length) && $stable(status) && $stable(run_end))
    else $error("stalled result changed");

  // Operation results carry ok status and a known code
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_OP |-> status == ST_OK && op_code <= OP_X)
    else $error("bad operation result");

  // Record end carries zero code and length and closes its byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_END |-> op_code == '0 && op_length == '0 && run_end)
    else $error("bad record end result");

  // Record end status is one of the defined codes
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_END |-> status <= ST_LEN_RANGE)
    else $error("record end status out of range");

  // Reset empties the result queue and opens the input
  assert property (@(posedge clk) rst |=> !result_valid && text_ready)
    else $error("queue not empty or input closed after reset");

endmodule

bind cigar_text_parser_core ctp_checker u_chk (.*);
